FILE: sv/bqf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bqf_pkg
// Shared constants for the transposed direct form II biquad core: default
// widths, coefficient register indexes and the fixed state word width.
// ----------------------------------------------------------------------------
package bqf_pkg;

    localparam int BQF_SAMPLE_WIDTH = 24;
    localparam int BQF_COEF_WIDTH   = 32;
    localparam int BQF_STATE_WIDTH  = 32;
    localparam int BQF_COEF_FRAC    = 4;
    localparam int BQF_NUM_COEFS    = 5;
    localparam int BQF_ADDR_WIDTH   = 3;

    localparam logic [BQF_ADDR_WIDTH-1:0] REG_COEF_A0 = 3'd0;
    localparam logic [BQF_ADDR_WIDTH-1:0] REG_COEF_A1 = 3'd1;
    localparam logic [BQF_ADDR_WIDTH-1:0] REG_COEF_A2 = 3'd2;
    localparam logic [BQF_ADDR_WIDTH-1:0] REG_COEF_B1 = 3'd3;
    localparam logic [BQF_ADDR_WIDTH-1:0] REG_COEF_B2 = 3'd4;

endpackage : bqf_pkg
`default_nettype wire

FILE: sv/biquad_filter_tdf2_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// biquad_filter_tdf2_core
// Second-order IIR filter, transposed direct form II, with one shared
// multiplier and one shared adder stepped by a small sequencer.
// ----------------------------------------------------------------------------
// Each sample steps through ST_Y, ST_N1A, ST_N1B, ST_N2A and ST_N2B, the last
// of which loads its result, and no new sample is accepted before that, as
// the five products y = x*a0 + s1,
// s1 = x*a1 + s2 - b1*y, s2 = x*a2 - b2*y passing one at a time through a
// single registered SAMPLE_WIDTH x COEF_WIDTH multiplier; s_axis_tready is
// high only between samples, and the last step waits while a previous result
// is still held on the master side. Coefficients are signed Q4.(COEF_WIDTH-4),
// reset to pass-through (a0 = 1.0); products are floored to the sample scale,
// the 32-bit state words saturate, y saturates to SAMPLE_WIDTH bits and
// m_axis_tuser flags any saturation in that sample. Coefficients may be
// written only while the core is idle.
// ----------------------------------------------------------------------------
module biquad_filter_tdf2_core
    import bqf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = BQF_SAMPLE_WIDTH,
    parameter int COEF_WIDTH   = BQF_COEF_WIDTH
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,

    input  wire logic                        cfg_wr_en,
    input  wire logic [BQF_ADDR_WIDTH-1:0]   cfg_addr,
    input  wire logic [COEF_WIDTH-1:0]       cfg_wdata,

    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // [SAMPLE_WIDTH-1:0] sample_in, rest zero
    input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,

    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // [SAMPLE_WIDTH-1:0] sample_out, rest zero
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // [0] clipped
    output logic                             m_axis_tuser
);

    localparam int TDATA_WIDTH = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int SHIFT       = COEF_WIDTH - BQF_COEF_FRAC;
    localparam int PROD_WIDTH  = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int SCALED_W    = SAMPLE_WIDTH + BQF_COEF_FRAC;
    localparam int ACC_WIDTH   = ((SCALED_W > BQF_STATE_WIDTH) ? SCALED_W : BQF_STATE_WIDTH) + 2;
    localparam int SW          = BQF_STATE_WIDTH;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_Y    = 3'd1;
    localparam logic [2:0] ST_N1A  = 3'd2;
    localparam logic [2:0] ST_N1B  = 3'd3;
    localparam logic [2:0] ST_N2A  = 3'd4;
    localparam logic [2:0] ST_N2B  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    logic signed [COEF_WIDTH-1:0]   coef_a0_reg;
    logic signed [COEF_WIDTH-1:0]   coef_a1_reg;
    logic signed [COEF_WIDTH-1:0]   coef_a2_reg;
    logic signed [COEF_WIDTH-1:0]   coef_b1_reg;
    logic signed [COEF_WIDTH-1:0]   coef_b2_reg;

    logic signed [SW-1:0]           delay_one_reg;
    logic signed [SW-1:0]           delay_two_reg;

    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [SAMPLE_WIDTH-1:0] y_reg;
    logic signed [PROD_WIDTH-1:0]   prod_reg;
    logic signed [ACC_WIDTH-1:0]    acc_reg;
    logic                           clip_reg;

    logic                           out_valid_reg;
    logic [SAMPLE_WIDTH-1:0]        out_data_reg;
    logic                           out_user_reg;

    logic signed [SAMPLE_WIDTH-1:0] mul_a;
    logic signed [COEF_WIDTH-1:0]   mul_b;
    logic signed [PROD_WIDTH-1:0]   mul_p;

    logic [SCALED_W-1:0]            p_scaled;
    logic signed [ACC_WIDTH-1:0]    p_ext;
    logic signed [ACC_WIDTH-1:0]    add_a;
    logic                           add_sub;
    logic signed [ACC_WIDTH-1:0]    add_res;

    logic                           y_ovf;
    logic [SAMPLE_WIDTH-1:0]        y_sat;
    logic                           s_ovf;
    logic [SW-1:0]                  s_sat;

    logic                           in_fire;
    logic                           out_free;
    logic [TDATA_WIDTH-1:0]         tdata_out;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // multiplier operand select
    always_comb
    begin
        case (state_reg)
            ST_IDLE:
            begin
                mul_a = s_axis_tdata[SAMPLE_WIDTH-1:0];
                mul_b = coef_a0_reg;
            end
            ST_Y:
            begin
                mul_a = x_reg;
                mul_b = coef_a1_reg;
            end
            ST_N1A:
            begin
                mul_a = y_reg;
                mul_b = coef_b1_reg;
            end
            ST_N1B:
            begin
                mul_a = x_reg;
                mul_b = coef_a2_reg;
            end
            ST_N2A:
            begin
                mul_a = y_reg;
                mul_b = coef_b2_reg;
            end
            default:
            begin
                mul_a = x_reg;
                mul_b = coef_a0_reg;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // floor to sample scale
    assign p_scaled = prod_reg[PROD_WIDTH-1:SHIFT];
    assign p_ext    = {{(ACC_WIDTH-SCALED_W){p_scaled[SCALED_W-1]}}, p_scaled};

    // shared adder
    always_comb
    begin
        add_sub = 1'b0;
        case (state_reg)
            ST_Y:   add_a = {{(ACC_WIDTH-SW){delay_one_reg[SW-1]}}, delay_one_reg};
            ST_N1A: add_a = {{(ACC_WIDTH-SW){delay_two_reg[SW-1]}}, delay_two_reg};
            ST_N1B:
            begin
                add_a   = acc_reg;
                add_sub = 1'b1;
            end
            ST_N2B:
            begin
                add_a   = acc_reg;
                add_sub = 1'b1;
            end
            default: add_a = '0;
        endcase
    end

    assign add_res = add_sub ? (add_a - p_ext) : (add_a + p_ext);

    assign y_ovf = (add_res[ACC_WIDTH-1:SAMPLE_WIDTH-1]
                    != {(ACC_WIDTH-SAMPLE_WIDTH+1){add_res[ACC_WIDTH-1]}});
    assign y_sat = !y_ovf ? add_res[SAMPLE_WIDTH-1:0]
                 : (add_res[ACC_WIDTH-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                                         : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}});

    assign s_ovf = (add_res[ACC_WIDTH-1:SW-1] != {(ACC_WIDTH-SW+1){add_res[ACC_WIDTH-1]}});
    assign s_sat = !s_ovf ? add_res[SW-1:0]
                 : (add_res[ACC_WIDTH-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}});

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_fire) state_next = ST_Y;
            ST_Y:    state_next = ST_N1A;
            ST_N1A:  state_next = ST_N1B;
            ST_N1B:  state_next = ST_N2A;
            ST_N2A:  state_next = ST_N2B;
            ST_N2B:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // control, coefficients and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            coef_a0_reg   <= COEF_WIDTH'(1) << SHIFT;
            coef_a1_reg   <= '0;
            coef_a2_reg   <= '0;
            coef_b1_reg   <= '0;
            coef_b2_reg   <= '0;
            delay_one_reg <= '0;
            delay_two_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    REG_COEF_A0: coef_a0_reg <= cfg_wdata;
                    REG_COEF_A1: coef_a1_reg <= cfg_wdata;
                    REG_COEF_A2: coef_a2_reg <= cfg_wdata;
                    REG_COEF_B1: coef_b1_reg <= cfg_wdata;
                    REG_COEF_B2: coef_b2_reg <= cfg_wdata;
                    default:     ;
                endcase
            end

            if (state_reg == ST_N1B)
                delay_one_reg <= s_sat;

            if ((state_reg == ST_N2B) && out_free)
            begin
                delay_two_reg <= s_sat;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
            x_reg <= s_axis_tdata[SAMPLE_WIDTH-1:0];

        if (state_reg != ST_N2B)
            prod_reg <= mul_p;

        case (state_reg)
            ST_Y:
            begin
                y_reg    <= y_sat;
                clip_reg <= y_ovf;
            end
            ST_N1A: acc_reg <= add_res;
            ST_N1B: clip_reg <= clip_reg | s_ovf;
            ST_N2A: acc_reg <= p_ext;
            default: ;
        endcase

        if ((state_reg == ST_N2B) && out_free)
        begin
            out_data_reg <= y_reg;
            out_user_reg <= clip_reg | s_ovf;
        end
    end

    always_comb
    begin
        tdata_out                   = '0;
        tdata_out[SAMPLE_WIDTH-1:0] = out_data_reg;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = tdata_out;
    assign m_axis_tuser  = out_user_reg;

`ifndef ASSERT_OFF
    a_fire_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_Y))
        else $error("accepted sample did not start the sequence");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_N2B) && !out_free |=> (state_reg == ST_N2B) && $stable(delay_two_reg))
        else $error("last step advanced while result slot was occupied");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_N2B))
        else $error("result appeared outside the final step");
`endif

endmodule : biquad_filter_tdf2_core
`default_nettype wire
